// File: hdl/scpu_pkg.sv
// Package for the small CPU execute unit: operation codes, flag bits, sizes.
// No dependencies.
package scpu_pkg;

    localparam int RAM_WORDS_DEF    = 4096;
    localparam int GENERAL_REGS_DEF = 12;
    localparam int VRAM_WORDS       = 48;
    // one VRAM entry per pixel column: red, green and blue planes side by side
    localparam int VRAM_COLS        = 16;

    typedef enum logic [4:0] {
        OP_MOV = 5'd0, OP_LDI = 5'd1, OP_LDM = 5'd2, OP_LPX = 5'd3,
        OP_SPX = 5'd4, OP_STR = 5'd5, OP_PUSH = 5'd6, OP_POP = 5'd7,
        OP_ADD = 5'd8, OP_ADDI = 5'd9, OP_SUB = 5'd10, OP_SUBI = 5'd11,
        OP_CMP = 5'd12, OP_AND = 5'd13, OP_OR = 5'd14, OP_XOR = 5'd15,
        OP_SHL = 5'd16, OP_SHR = 5'd17, OP_JMP = 5'd18, OP_JE = 5'd19,
        OP_JNE = 5'd20, OP_JG = 5'd21, OP_JGE = 5'd22, OP_JL = 5'd23,
        OP_JLE = 5'd24, OP_JZ = 5'd25, OP_JNZ = 5'd26, OP_CALL = 5'd27,
        OP_CALL_IMM = 5'd28, OP_RET = 5'd29, OP_HLT = 5'd30, OP_NOOP = 5'd31
    } op_t;

    localparam logic [3:0] REG_IP = 4'd12;
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_DP = 4'd14;
    localparam logic [3:0] REG_PX = 4'd15;

    localparam int FLAG_ZERO    = 0;
    localparam int FLAG_LESS    = 1;
    localparam int FLAG_GREATER = 2;
    localparam int FLAG_EQUAL   = 3;

endpackage

// File: hdl/small_cpu_execute_unit.sv
// Top level of the small CPU execute unit: register file, flags, data RAM,
// pixel VRAM and the execute sequencer. Depends on scpu_pkg.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  request | in_valid/in_ready, func dest_reg src_reg immediate | in
//  result  | out_valid/out_ready, next_ip halted rom_end pixel_* | out
//
// Each request passes through a read step, in which the data RAM is read
// at dp or sp into a register, and an execute step, in which registers,
// flags, RAM and VRAM are written and the result is registered.
// A new request is accepted only while the execute stage is empty.
// A stalled result occupies the output register; one more request may be
// read meanwhile and then waits in the execute stage until the register frees.
// Reset clears registers, pointers, flags, stop state and the VRAM at once;
// the data RAM holds no reset value.
module small_cpu_execute_unit #(
    parameter int GENERAL_REGS = scpu_pkg::GENERAL_REGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  func,
    input  logic [3:0]  dest_reg,
    input  logic [3:0]  src_reg,
    input  logic [15:0] immediate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] next_ip,
    output logic        halted,
    output logic        rom_end,
    output logic        pixel_written,
    output logic [7:0]  pixel_index,
    output logic [2:0]  pixel_color
);

    localparam int AW = $clog2(scpu_pkg::RAM_WORDS_DEF);
    localparam int GW = (GENERAL_REGS > 1) ? $clog2(GENERAL_REGS) : 1;

    logic [15:0] gen_reg [GENERAL_REGS];
    logic [15:0] ip_reg, sp_reg, dp_reg, px_reg;
    logic [3:0]  flags_reg;
    logic        halt_reg, end_reg;
    logic [15:0] ram [scpu_pkg::RAM_WORDS_DEF];
    logic [scpu_pkg::VRAM_WORDS-1:0] vram_reg [scpu_pkg::VRAM_COLS];
    logic [15:0] rdata_reg;

    // execute stage holding register
    logic        ex_valid_reg;
    logic [4:0]  ex_func_reg;
    logic [3:0]  ex_d_reg, ex_s_reg;
    logic [15:0] ex_imm_reg;

    logic ex_fire;
    assign ex_fire  = ex_valid_reg && (!out_valid || out_ready);
    // Accept a new request only while the execute stage is empty, so that the
    // RAM read always sees the pointers left by the previous one.
    assign in_ready = !ex_valid_reg;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // read port: pop and ret read at sp, everything else at dp
    logic [AW-1:0] rd_addr;
    always_comb
    begin
        if (func == scpu_pkg::OP_POP || func == scpu_pkg::OP_RET)
            rd_addr = sp_reg[AW-1:0];
        else
            rd_addr = dp_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            rdata_reg <= ram[rd_addr];
    end

    function automatic logic [15:0] rd_reg(input logic [3:0] a,
        input logic [15:0] g [GENERAL_REGS], input logic [15:0] ip,
        input logic [15:0] sp, input logic [15:0] dp, input logic [15:0] px);
        logic [15:0] r;
        r = 16'd0;
        if (a == scpu_pkg::REG_IP)      r = ip;
        else if (a == scpu_pkg::REG_SP) r = sp;
        else if (a == scpu_pkg::REG_DP) r = dp;
        else if (a == scpu_pkg::REG_PX) r = px;
        else if (32'(a) < GENERAL_REGS) r = g[a[GW-1:0]];
        return r;
    endfunction

    logic [15:0] va, vb;
    assign va = rd_reg(ex_d_reg, gen_reg, ip_reg, sp_reg, dp_reg, px_reg);
    assign vb = rd_reg(ex_s_reg, gen_reg, ip_reg, sp_reg, dp_reg, px_reg);

    // execute: compute writes
    logic        wr_en;
    logic [15:0] wr_val, ip_next, sp_next, dp_next, px_next;
    logic [3:0]  flags_next;
    logic        halt_next, ram_we, px_we, take_jmp;
    logic [15:0] ram_waddr, ram_wdata, sum;
    logic [7:0]  p;
    always_comb
    begin
        wr_en = 1'b0; wr_val = 16'd0; ip_next = ip_reg; sp_next = sp_reg;
        dp_next = dp_reg; px_next = px_reg;
        flags_next = flags_reg; halt_next = halt_reg; ram_we = 1'b0;
        ram_waddr = dp_reg; ram_wdata = vb; px_we = 1'b0; take_jmp = 1'b0;
        p = px_reg[7:0];
        sum = 16'd0;
        case (ex_func_reg)
            scpu_pkg::OP_MOV:  begin wr_en = 1'b1; wr_val = vb; end
            scpu_pkg::OP_LDI:  begin wr_en = 1'b1; wr_val = ex_imm_reg; end
            scpu_pkg::OP_LDM:  begin wr_en = 1'b1; wr_val = rdata_reg; end
            scpu_pkg::OP_SPX:  px_we = 1'b1;
            scpu_pkg::OP_STR:  ram_we = 1'b1;
            scpu_pkg::OP_PUSH:
            begin
                sp_next = sp_reg - 16'd1; ram_we = 1'b1; ram_waddr = sp_next;
                ram_wdata = (ex_s_reg == scpu_pkg::REG_SP) ? sp_next : vb;
            end
            scpu_pkg::OP_POP:
            begin
                sp_next = sp_reg + 16'd1; wr_en = 1'b1; wr_val = rdata_reg;
                if (ex_d_reg == scpu_pkg::REG_SP) sp_next = rdata_reg + 16'd1;
            end
            scpu_pkg::OP_ADD, scpu_pkg::OP_ADDI, scpu_pkg::OP_SUB,
            scpu_pkg::OP_SUBI:
            begin
                if (ex_func_reg == scpu_pkg::OP_ADD)       sum = va + vb;
                else if (ex_func_reg == scpu_pkg::OP_ADDI) sum = va + ex_imm_reg;
                else if (ex_func_reg == scpu_pkg::OP_SUB)  sum = va - vb;
                else                                       sum = va - ex_imm_reg;
                wr_en = 1'b1; wr_val = sum;
                // zero flag reads back the destination: an absent register stays 0
                flags_next[scpu_pkg::FLAG_ZERO] = (ex_d_reg < 4'd12
                    && 32'(ex_d_reg) >= GENERAL_REGS) ? 1'b1 : (sum == 16'd0);
            end
            scpu_pkg::OP_CMP:
            begin
                flags_next[scpu_pkg::FLAG_LESS]    = va < vb;
                flags_next[scpu_pkg::FLAG_GREATER] = va > vb;
                flags_next[scpu_pkg::FLAG_EQUAL]   = va == vb;
            end
            scpu_pkg::OP_AND:  begin wr_en = 1'b1; wr_val = va & vb; end
            scpu_pkg::OP_OR:   begin wr_en = 1'b1; wr_val = va | vb; end
            scpu_pkg::OP_XOR:  begin wr_en = 1'b1; wr_val = va ^ vb; end
            scpu_pkg::OP_SHL:  begin wr_en = 1'b1; wr_val = {va[14:0], 1'b0}; end
            scpu_pkg::OP_SHR:  begin wr_en = 1'b1; wr_val = {1'b0, va[15:1]}; end
            scpu_pkg::OP_JMP:  take_jmp = 1'b1;
            scpu_pkg::OP_JE:   take_jmp = flags_reg[scpu_pkg::FLAG_EQUAL];
            scpu_pkg::OP_JNE:  take_jmp = !flags_reg[scpu_pkg::FLAG_EQUAL];
            scpu_pkg::OP_JG:   take_jmp = flags_reg[scpu_pkg::FLAG_GREATER];
            scpu_pkg::OP_JGE:  take_jmp = flags_reg[scpu_pkg::FLAG_GREATER]
                                       || flags_reg[scpu_pkg::FLAG_EQUAL];
            scpu_pkg::OP_JL:   take_jmp = flags_reg[scpu_pkg::FLAG_LESS];
            scpu_pkg::OP_JLE:  take_jmp = flags_reg[scpu_pkg::FLAG_LESS]
                                       || flags_reg[scpu_pkg::FLAG_EQUAL];
            scpu_pkg::OP_JZ:   take_jmp = flags_reg[scpu_pkg::FLAG_ZERO];
            scpu_pkg::OP_JNZ:  take_jmp = !flags_reg[scpu_pkg::FLAG_ZERO];
            scpu_pkg::OP_CALL:
            begin
                sp_next = sp_reg - 16'd1; ram_we = 1'b1; ram_waddr = sp_next;
                ram_wdata = ip_reg + 16'd1;
                // target reads sp after the decrement
                ip_next = ((ex_d_reg == scpu_pkg::REG_SP) ? sp_next : va) - 16'd1;
            end
            scpu_pkg::OP_CALL_IMM:
            begin
                sp_next = sp_reg - 16'd1; ram_we = 1'b1; ram_waddr = sp_next;
                ram_wdata = ip_reg + 16'd1; ip_next = ex_imm_reg - 16'd1;
            end
            scpu_pkg::OP_RET:
            begin
                sp_next = sp_reg + 16'd1; ip_next = rdata_reg - 16'd1;
            end
            scpu_pkg::OP_HLT:  halt_next = 1'b1;
            default: ;
        endcase
        if (take_jmp)
            ip_next = va - 16'd1;
        if (wr_en && ex_d_reg == scpu_pkg::REG_IP)
            ip_next = wr_val;
        // pop into sp already set sp from the popped word
        if (wr_en)
        begin
            if (ex_d_reg == scpu_pkg::REG_SP)
            begin
                if (ex_func_reg != scpu_pkg::OP_POP) sp_next = wr_val;
            end
            else if (ex_d_reg == scpu_pkg::REG_DP) dp_next = wr_val;
            else if (ex_d_reg == scpu_pkg::REG_PX) px_next = wr_val;
        end
        if (!halt_next)
            ip_next = ip_next + 16'd1;
    end

    // VRAM column update: set or clear bit "row" in each colour plane
    logic [scpu_pkg::VRAM_WORDS-1:0] vcol_next;
    always_comb
    begin
        vcol_next = vram_reg[px_reg[7:4]];
        vcol_next[{2'b00, px_reg[3:0]}] = vb[0];
        vcol_next[{2'b01, px_reg[3:0]}] = vb[1];
        vcol_next[{2'b10, px_reg[3:0]}] = vb[2];
    end

    logic running;
    assign running = !halt_reg && !end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            ex_func_reg  <= '0; ex_d_reg <= '0; ex_s_reg <= '0; ex_imm_reg <= '0;
            out_valid    <= 1'b0;
            ip_reg <= '0; sp_reg <= '0; dp_reg <= '0; px_reg <= '0;
            flags_reg <= '0; halt_reg <= 1'b0; end_reg <= 1'b0;
            for (int i = 0; i < GENERAL_REGS; i++) gen_reg[i] <= '0;
            for (int i = 0; i < scpu_pkg::VRAM_COLS; i++) vram_reg[i] <= '0;
            next_ip <= '0; halted <= 1'b0; rom_end <= 1'b0;
            pixel_written <= 1'b0; pixel_index <= '0; pixel_color <= '0;
        end
        else
        begin
            if (ex_fire)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
            if (in_fire)
            begin
                ex_valid_reg <= 1'b1;
                ex_func_reg <= func; ex_d_reg <= dest_reg;
                ex_s_reg <= src_reg; ex_imm_reg <= immediate;
            end
            else if (ex_fire)
                ex_valid_reg <= 1'b0;
            if (ex_fire)
            begin
                pixel_written <= running && px_we;
                pixel_index   <= (running && px_we) ? p : 8'd0;
                pixel_color   <= (running && px_we) ? vb[2:0] : 3'd0;
                if (running)
                begin
                    flags_reg <= flags_next;
                    halt_reg  <= halt_next;
                    ip_reg    <= ip_next;
                    sp_reg    <= sp_next;
                    dp_reg    <= dp_next;
                    px_reg    <= px_next;
                    end_reg   <= !halt_next && ip_next == 16'd0;
                    next_ip   <= ip_next;
                    halted    <= halt_next;
                    rom_end   <= !halt_next && ip_next == 16'd0;
                    if (wr_en && ex_d_reg < scpu_pkg::REG_IP
                        && 32'(ex_d_reg) < GENERAL_REGS)
                        gen_reg[ex_d_reg[GW-1:0]] <= wr_val;
                    if (px_we)
                        vram_reg[px_reg[7:4]] <= vcol_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire && running && ram_we)
            ram[ram_waddr[AW-1:0]] <= ram_wdata;
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result lost");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        ex_valid_reg |-> !in_ready) else $error("second request accepted");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg) else $error("halt cleared");
    a_stopped_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !running |=> $stable(ip_reg) && $stable(sp_reg)) else $error("state moved");
`endif

endmodule
